[hw/rtl/pic_pkg.sv]
// Shared types and constants for the pixel integer class converter.
// No dependencies; imported by pic_widen, pic_narrow and the top level.
package pic_pkg;

  // Pixel class codes, as held in the class registers
  typedef enum logic [1:0] {
    CLS_U8  = 2'd0,
    CLS_U16 = 2'd1,
    CLS_I16 = 2'd2,
    CLS_LOG = 2'd3
  } class_t;

  // Configuration register indexes
  localparam logic REG_SOURCE = 1'b0;
  localparam logic REG_TARGET = 1'b1;

  localparam int SampleW = 16;
  localparam int ByteW   = 8;
  localparam int SumW    = SampleW + 1;

  // Offset between int16 and uint16 is a flip of the sign bit
  localparam logic [SampleW-1:0] SIGN_FLIP = 16'h8000;
  localparam logic [SampleW-1:0] FULL_U16  = 16'hFFFF;
  localparam logic [SampleW-1:0] FULL_U8   = 16'h00FF;
  localparam logic [SampleW-1:0] MAX_I16   = 16'h7FFF;
  localparam logic [SampleW-1:0] MIN_I16   = 16'h8000;

  // round(v / 257): add half the divisor, then multiply by the reciprocal
  localparam logic [SumW-1:0] HALF_DIV = 17'd128;
  localparam logic [SumW-1:0] DIVISOR  = 17'd257;
  // floor(2^24 / 257); the estimate is low by at most one
  localparam logic [15:0]     RECIP    = 16'd65280;
  localparam int              RecipSh  = 24;
  localparam int              ProdW    = SumW + 16;

  // Stage-1 result handed from the widen stage to the narrow pipeline
  typedef struct packed {
    logic               valid;
    logic               direct;  // final value known, no division needed
    logic [SampleW-1:0] dval;    // final value when direct
    logic [SampleW-1:0] wide;    // sample on the uint16 scale
  } mid_t;

endpackage

[hw/rtl/pic_widen.sv]
// First pipeline stage: brings the sample to the uint16 scale and resolves
// every conversion that needs no division. Depends on pic_pkg.
module pic_widen (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [pic_pkg::SampleW-1:0]     sample,
  input  pic_pkg::class_t                 source_class,
  input  logic [1:0]                      target_class,
  output pic_pkg::mid_t                   mid
);
  import pic_pkg::*;

  logic [SampleW-1:0] wide;
  logic [SampleW-1:0] dval;
  logic               direct;
  logic               on;

  // Widen to uint16 scale per source class
  always_comb begin
    on = (sample != '0);
    unique case (source_class)
      CLS_U8:  wide = {sample[ByteW-1:0], sample[ByteW-1:0]};
      CLS_U16: wide = sample;
      CLS_I16: wide = sample ^ SIGN_FLIP;
      default: wide = on ? FULL_U16 : '0;
    endcase
  end

  // Pick the final value where no division is involved
  always_comb begin
    direct = 1'b1;
    dval   = '0;
    if (source_class == CLS_LOG) begin
      unique case (target_class)
        CLS_U8:  dval = on ? FULL_U8 : '0;
        CLS_U16: dval = on ? FULL_U16 : '0;
        CLS_I16: dval = on ? MAX_I16 : MIN_I16;
        default: dval = '0;
      endcase
    end else begin
      unique case (target_class)
        CLS_U8: begin
          if (source_class == CLS_U8) begin
            dval = {{(SampleW-ByteW){1'b0}}, sample[ByteW-1:0]};
          end else begin
            direct = 1'b0;
          end
        end
        CLS_U16: dval = wide;
        CLS_I16: dval = wide ^ SIGN_FLIP;
        default: dval = '0;
      endcase
    end
  end

  // Stage-1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid <= 1'b0;
    end else begin
      mid.valid <= accept;
    end
    mid.direct <= direct;
    mid.dval   <= dval;
    mid.wide   <= wide;
  end

endmodule

[hw/rtl/pic_narrow.sv]
// Stages two to four: round(wide / 257) by reciprocal multiply with one
// correction step, then the output register. Depends on pic_pkg.
module pic_narrow (
  input  logic                        clk,
  input  logic                        rst,
  input  pic_pkg::mid_t               mid,
  output logic                        done,
  output logic [pic_pkg::SampleW-1:0] converted
);
  import pic_pkg::*;

  // Stage 2: rounding offset
  logic               s2_valid;
  logic               s2_direct;
  logic [SampleW-1:0] s2_dval;
  logic [SumW-1:0]    s2_sum;

  // Stage 3: reciprocal product
  logic               s3_valid;
  logic               s3_direct;
  logic [SampleW-1:0] s3_dval;
  logic [SumW-1:0]    s3_sum;
  logic [ProdW-1:0]   s3_prod;

  // Stage 4 logic: quotient correction
  logic [ByteW-1:0]   q_est;
  logic [SumW-1:0]    q_mul;
  logic [SumW-1:0]    rem;
  logic [ByteW-1:0]   quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s2_valid <= mid.valid;
      s3_valid <= s2_valid;
      done     <= s3_valid;
    end
    s2_direct <= mid.direct;
    s2_dval   <= mid.dval;
    s2_sum    <= {1'b0, mid.wide} + HALF_DIV;
    s3_direct <= s2_direct;
    s3_dval   <= s2_dval;
    s3_sum    <= s2_sum;
    s3_prod   <= ProdW'(s2_sum) * ProdW'(RECIP);
  end

  // Estimate is floor or one below; fix with one compare and add
  always_comb begin
    q_est = s3_prod[RecipSh+ByteW-1:RecipSh];
    q_mul = {1'b0, q_est, {ByteW{1'b0}}} + {{(SumW-ByteW){1'b0}}, q_est};
    rem   = s3_sum - q_mul;
    quot  = (rem >= DIVISOR) ? q_est + 8'd1 : q_est;
  end

  // Output register
  always_ff @(posedge clk) begin
    converted <= s3_direct ? s3_dval : {{(SampleW-ByteW){1'b0}}, quot};
  end

  // Every item that leaves stage one reaches done, through the stage-2 and stage-3 registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    mid.valid |-> ##3 done)
    else $error("pic_narrow: item did not reach output");

  // Reciprocal estimate is never more than one low
  a_recip: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !s3_direct) |-> (rem < (DIVISOR + DIVISOR)))
    else $error("pic_narrow: reciprocal estimate out of range");

  // A narrowed result fits in the low byte
  a_narrow: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !s3_direct) |=> (converted[SampleW-1:ByteW] == '0))
    else $error("pic_narrow: narrowed result exceeds a byte");

endmodule

[hw/rtl/pixel_integer_class_converter.sv]
// Path: a sample taken at a clock edge passes the stage-1, stage-2 and
// stage-3 registers and the output register, then shows on converted with done high.
// Throughput: one sample per cycle; busy is never raised, and results
// cannot be held off. The reciprocal multiply sets the stage depth.
// Reset (rst, synchronous): empties the pipeline, source_class = uint8,
// target_class = uint16.
module pixel_integer_class_converter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [pic_pkg::SampleW-1:0] sample,
  output logic                        done,
  output logic [pic_pkg::SampleW-1:0] converted,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [1:0]                  cfg_data
);
  import pic_pkg::*;

  class_t     source_class;
  logic [1:0] target_class;
  logic       accept;
  mid_t       mid;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_class <= CLS_U8;
      target_class <= CLS_U16;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SOURCE: source_class <= class_t'(cfg_data);
        REG_TARGET: target_class <= cfg_data;
        default:    target_class <= target_class;
      endcase
    end
  end

  pic_widen u_widen (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .sample       (sample),
    .source_class (source_class),
    .target_class (target_class),
    .mid          (mid)
  );

  pic_narrow u_narrow (
    .clk       (clk),
    .rst       (rst),
    .mid       (mid),
    .done      (done),
    .converted (converted)
  );

endmodule
